### design/bump_turn_avoidance_controller_assert.svh
// Assertion macros shared by the bump-and-turn avoidance controller
`ifndef BUMP_TURN_AVOIDANCE_CONTROLLER_ASSERT_SVH
`define BUMP_TURN_AVOIDANCE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define BTAC_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define BTAC_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/btac_pkg.sv
// Types and constants of the bump-and-turn avoidance controller
package btac_pkg;

    typedef struct packed {
        logic left_hit;
        logic right_hit;
        logic coin;
    } in_t;

    typedef struct packed {
        logic       left_drive;
        logic       right_drive;
        logic [1:0] phase;
    } out_t;

    // One-hot phase state
    typedef enum logic [2:0] {
        PH_FWD  = 3'b001,
        PH_REV  = 3'b010,
        PH_TURN = 3'b100
    } phase_t;

    // Phase codes on the result channel
    localparam logic [1:0] PHASE_CODE_FWD  = 2'd0;
    localparam logic [1:0] PHASE_CODE_REV  = 2'd1;
    localparam logic [1:0] PHASE_CODE_TURN = 2'd2;

    // Turn directions
    localparam logic DIR_LEFT  = 1'b0;
    localparam logic DIR_RIGHT = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_REVERSE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_TURN_BASE     = 2'd1;
    localparam logic [1:0] CFG_REPEAT_WINDOW = 2'd2;
    localparam logic [1:0] CFG_BIAS_LIMIT    = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 14;

    // Counter widths and saturation points
    localparam int FWD_W   = 12;
    localparam int AVOID_W = 14;
    localparam int LEFT_W  = 16;
    localparam int REP_W   = 4;
    localparam int LIM_W   = 7;

    localparam logic [FWD_W-1:0]   FWD_SAT   = {FWD_W{1'b1}};
    localparam logic [AVOID_W-1:0] AVOID_SAT = {AVOID_W{1'b1}};

    // Register reset values
    localparam logic [FWD_W-1:0]   REVERSE_LIMIT_RST = 12'd500;
    localparam logic [FWD_W-1:0]   TURN_BASE_RST     = 12'd500;
    localparam logic [AVOID_W-1:0] REPEAT_WINDOW_RST = 14'd1500;
    localparam logic [LIM_W-1:0]   BIAS_LIMIT_RST    = 7'd6;

endpackage

### design/bump_turn_avoidance_controller.sv
// Bump-and-turn obstacle avoidance controller, one tick per transaction
//
//   channel | direction | payload                          | handshake
//   s_      | in        | left_hit, right_hit, coin        | s_valid / s_ready
//   m_      | out       | left_drive, right_drive, phase   | m_valid / m_ready
//   cfg_    | in        | reverse/turn/window/bias limits  | cfg_we, no wait
//
// One tick per cycle while s_ready is high: the whole decision and state
// update sit between the state registers and the result register. A
// two-entry output buffer (result register plus skid) keeps s_ready high
// while one result waits; s_ready drops only with both full. Reset is
// synchronous, active low, and needs no clearing pass.
`include "bump_turn_avoidance_controller_assert.svh"

module bump_turn_avoidance_controller
    import btac_pkg::*;
#(
    parameter int REPEAT_MAX = 15,
    parameter int BIAS_BITS  = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_t                    s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_t                   m_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CMP_W = ((BIAS_BITS > LIM_W) ? BIAS_BITS : LIM_W) + 1;
    localparam logic signed [BIAS_BITS-1:0] BIAS_MAX = {1'b0, {(BIAS_BITS-1){1'b1}}};
    localparam logic [REP_W-1:0] REP_MAX = REP_W'(REPEAT_MAX);

    // Configuration registers
    logic [FWD_W-1:0]   reverse_limit_reg;
    logic [FWD_W-1:0]   turn_base_reg;
    logic [AVOID_W-1:0] repeat_window_reg;
    logic [LIM_W-1:0]   bias_limit_reg;

    // Controller state
    phase_t                       phase_reg, phase_next;
    logic [LEFT_W-1:0]            left_reg, left_next;
    logic                         pend_reg, pend_next;
    logic signed [BIAS_BITS-1:0]  bias_reg, bias_next;
    logic                         prev_valid_reg, prev_valid_next;
    logic                         prev_dir_reg, prev_dir_next;
    logic [FWD_W-1:0]             since_fwd_reg, since_fwd_next;
    logic [AVOID_W-1:0]           since_avoid_reg, since_avoid_next;
    logic [REP_W-1:0]             rep_reg, rep_next;

    // Output buffer
    logic m_valid_reg;
    out_t m_data_reg;
    logic skid_valid_reg;
    out_t skid_data_reg;
    out_t result;

    logic accept, out_take;

    // Intermediate decision values
    logic                      hit;
    logic                      dir_raw, dir_final;
    logic signed [CMP_W-1:0]   bias_ext, lim_ext;
    phase_t                    ph_hit;
    logic [LEFT_W-1:0]         left_hit_val;
    logic [REP_W-1:0]          rep_hit;
    logic [FWD_W-1:0]          since_fwd_hit;
    logic [AVOID_W-1:0]        since_avoid_hit;
    logic [REP_W:0]            rep_plus;
    logic [LEFT_W-1:0]         turn_len;
    phase_t                    ph_mid;
    logic [LEFT_W-1:0]         left_mid;
    logic [1:0]                phase_code;

    assign accept   = s_valid && s_ready;
    assign out_take = m_valid_reg && m_ready;
    assign s_ready  = !skid_valid_reg;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign bias_ext = CMP_W'(bias_reg);
    assign lim_ext  = $signed({{(CMP_W-LIM_W){1'b0}}, bias_limit_reg});
    assign rep_plus = {1'b0, rep_hit} + (REP_W+1)'(1);
    assign turn_len = LEFT_W'(turn_base_reg) * LEFT_W'(rep_plus);

    // Decide the tick: contact, phase hand-over, result and counters
    always_comb begin
        // Escape direction before the bias override
        if (s_data.left_hit && s_data.right_hit) begin
            if (bias_reg > 0) begin
                dir_raw = DIR_RIGHT;
            end else if (bias_reg < 0) begin
                dir_raw = DIR_LEFT;
            end else if (prev_valid_reg) begin
                dir_raw = prev_dir_reg;
            end else begin
                dir_raw = s_data.coin;
            end
        end else if (s_data.left_hit) begin
            dir_raw = DIR_RIGHT;
        end else begin
            dir_raw = DIR_LEFT;
        end

        if (bias_ext > lim_ext) begin
            dir_final = DIR_RIGHT;
        end else if (bias_ext < -lim_ext) begin
            dir_final = DIR_LEFT;
        end else begin
            dir_final = dir_raw;
        end

        // Start an avoidance on contact while driving forward
        hit             = (phase_reg == PH_FWD) && (s_data.left_hit || s_data.right_hit);
        ph_hit          = phase_reg;
        left_hit_val    = left_reg;
        rep_hit         = rep_reg;
        since_avoid_hit = since_avoid_reg;
        pend_next       = pend_reg;
        if (hit) begin
            if (since_avoid_reg < repeat_window_reg) begin
                rep_hit = (rep_reg < REP_MAX) ? rep_reg + REP_W'(1) : rep_reg;
            end else begin
                rep_hit = '0;
            end
            since_avoid_hit = '0;
            pend_next       = dir_final;
            ph_hit          = PH_REV;
            left_hit_val    = (since_fwd_reg < reverse_limit_reg) ?
                              LEFT_W'(since_fwd_reg) : LEFT_W'(reverse_limit_reg);
        end

        // Hand reverse over to turn
        ph_mid          = ph_hit;
        left_mid        = left_hit_val;
        bias_next       = bias_reg;
        prev_valid_next = prev_valid_reg;
        prev_dir_next   = prev_dir_reg;
        if ((ph_hit == PH_REV) && (left_hit_val == '0)) begin
            ph_mid          = PH_TURN;
            prev_valid_next = 1'b1;
            prev_dir_next   = pend_next;
            if (pend_next == DIR_LEFT) begin
                if (bias_reg != BIAS_MAX) begin
                    bias_next = bias_reg + BIAS_BITS'(1);
                end
            end else begin
                if (bias_reg != -BIAS_MAX) begin
                    bias_next = bias_reg - BIAS_BITS'(1);
                end
            end
            left_mid = turn_len;
        end

        // Hand turn over to forward
        phase_next    = ph_mid;
        since_fwd_hit = since_fwd_reg;
        if ((ph_mid == PH_TURN) && (left_mid == '0)) begin
            phase_next    = PH_FWD;
            since_fwd_hit = '0;
        end

        // Drive pattern of the phase that holds
        result.left_drive  = 1'b0;
        result.right_drive = 1'b0;
        phase_code         = PHASE_CODE_FWD;
        case (phase_next)
            PH_REV: begin
                result.left_drive  = 1'b1;
                result.right_drive = 1'b1;
                phase_code         = PHASE_CODE_REV;
            end
            PH_TURN: begin
                result.left_drive  = (pend_next == DIR_LEFT);
                result.right_drive = (pend_next == DIR_RIGHT);
                phase_code         = PHASE_CODE_TURN;
            end
            default: begin
                phase_code = PHASE_CODE_FWD;
            end
        endcase
        result.phase = phase_code;

        // Count down the phase and advance elapsed times
        left_next = left_mid;
        if ((phase_next != PH_FWD) && (left_mid != '0)) begin
            left_next = left_mid - LEFT_W'(1);
        end
        since_fwd_next   = (since_fwd_hit != FWD_SAT) ?
                           since_fwd_hit + FWD_W'(1) : since_fwd_hit;
        since_avoid_next = (since_avoid_hit != AVOID_SAT) ?
                           since_avoid_hit + AVOID_W'(1) : since_avoid_hit;
        rep_next         = rep_hit;
    end

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reverse_limit_reg <= REVERSE_LIMIT_RST;
            turn_base_reg     <= TURN_BASE_RST;
            repeat_window_reg <= REPEAT_WINDOW_RST;
            bias_limit_reg    <= BIAS_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_REVERSE_LIMIT: reverse_limit_reg <= cfg_wdata[FWD_W-1:0];
                CFG_TURN_BASE:     turn_base_reg     <= cfg_wdata[FWD_W-1:0];
                CFG_REPEAT_WINDOW: repeat_window_reg <= cfg_wdata[AVOID_W-1:0];
                CFG_BIAS_LIMIT:    bias_limit_reg    <= cfg_wdata[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Advance controller state on each accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_FWD;
            left_reg        <= '0;
            pend_reg        <= DIR_LEFT;
            bias_reg        <= '0;
            prev_valid_reg  <= 1'b0;
            prev_dir_reg    <= DIR_LEFT;
            since_fwd_reg   <= '0;
            since_avoid_reg <= '0;
            rep_reg         <= '0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            left_reg        <= left_next;
            pend_reg        <= pend_next;
            bias_reg        <= bias_next;
            prev_valid_reg  <= prev_valid_next;
            prev_dir_reg    <= prev_dir_next;
            since_fwd_reg   <= since_fwd_next;
            since_avoid_reg <= since_avoid_next;
            rep_reg         <= rep_next;
        end
    end

    // Hold results in the result register, spill into skid when stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!m_valid_reg || out_take) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_take) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_take) begin
                m_data_reg <= skid_data_reg;
            end
        end else if (accept) begin
            if (!m_valid_reg || out_take) begin
                m_data_reg <= result;
            end else begin
                skid_data_reg <= result;
            end
        end
    end

    // Checks on buffer ordering and phase bookkeeping
    `BTAC_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_valid_reg, m_valid_reg,
        "skid entry held without a result in the output register")
    `BTAC_ASSERT_NOW(a_fwd_no_time_left, aclk, aresetn, phase_reg == PH_FWD, left_reg == '0,
        "phase time left while driving forward")
    `BTAC_ASSERT_NOW(a_rev_drives_back, aclk, aresetn,
        m_valid && (m_data.phase == PHASE_CODE_REV),
        m_data.left_drive && m_data.right_drive,
        "reverse phase shown without both sides backward")
    `BTAC_ASSERT_NEXT(a_avoid_clears_timer, aclk, aresetn, accept && hit,
        since_avoid_reg == AVOID_W'(1),
        "avoidance did not restart the repeat timer")

endmodule
